// File: rtl/core/krm_pkg.sv
// ----------------------------------------------------------------------------
// krm_pkg
// Shared types and constants for the keyed receipt mailbox.
// ----------------------------------------------------------------------------
`default_nettype none

package krm_pkg;

    localparam int DEPTH   = 16;
    localparam int CNT_RAW = $clog2(DEPTH + 1);
    localparam int CNT_W   = (CNT_RAW > 5) ? CNT_RAW : 5;

    localparam int DEST_W  = 16;
    localparam int KIND_W  = 5;
    localparam int AUX_W   = 16;
    localparam int WORD_W  = 64;
    localparam int STAT_W  = 2;
    localparam int RCNT_W  = 5;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_POP   = 2'd1,
        ACT_QUERY = 2'd2,
        ACT_PURGE = 2'd3
    } action_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 2'd0,
        STAT_NOMATCH = 2'd1,
        STAT_FULL    = 2'd2
    } status_t;

    typedef struct packed {
        logic [DEST_W-1:0] dest;
        logic [KIND_W-1:0] kind;
        logic [AUX_W-1:0]  aux;
        logic [WORD_W-1:0] handler;
        logic [WORD_W-1:0] param;
    } slot_t;

    // Broadcast to every cell
    typedef struct packed {
        logic compare;
        logic push;
        logic remove;
    } cell_ctrl_t;

    // What a cell hands to its lower neighbor when the row shifts down
    typedef struct packed {
        logic  valid;
        logic  match;
        slot_t slot;
    } link_t;

endpackage

`default_nettype wire

// File: rtl/core/krm_cell.sv
// ----------------------------------------------------------------------------
// krm_cell
// One slot of the mailbox: holds an entry, its match flag, and takes the
// upper neighbor's entry when an earlier-or-own match is removed, or the pushed entry when it is the lowest empty slot.
// ----------------------------------------------------------------------------
`default_nettype none

module krm_cell
    import krm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [DEST_W-1:0] key,
    input  wire slot_t             push_slot,
    input  wire logic              prev_valid,
    input  wire logic              hit_in,
    input  wire link_t             up,
    output link_t                  down,
    output logic                   hit_out,
    output slot_t                  sel_slot
);

    logic  valid_reg;
    logic  match_reg;
    slot_t data_reg;

    logic  shift;
    logic  load;
    logic  first;

    assign shift   = ctrl.remove && (hit_in || match_reg);
    assign load    = ctrl.push && !valid_reg && prev_valid;
    assign first   = match_reg && !hit_in;
    assign hit_out = hit_in || match_reg;

    assign down.valid = valid_reg;
    assign down.match = match_reg;
    assign down.slot  = data_reg;

    assign sel_slot = first ? data_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else if (ctrl.compare)
        begin
            match_reg <= valid_reg && (data_reg.dest == key);
        end
        else if (shift)
        begin
            valid_reg <= up.valid;
            match_reg <= up.match;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            match_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!ctrl.compare && shift)
        begin
            data_reg <= up.slot;
        end
        else if (!ctrl.compare && load)
        begin
            data_reg <= push_slot;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/keyed_receipt_mailbox_top.sv
// ----------------------------------------------------------------------------
// keyed_receipt_mailbox_top
// Ordered receipt store with push, pop-oldest-match, query and purge by
// destination id, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Entries sit oldest first in a row of DEPTH cells, slot 0 at the bottom.
// A command is taken while the block is idle; in the cycle it is taken every
// cell compares its destination with dest_id. Push, pop and query then finish
// in a single execute step; a pop shifts every cell above the first match
// down by one. Purge removes one match per execute cycle while the execute
// step is not held, and finishes once no match is left. One result beat per
// command; a result waiting at the output holds the execute step until taken.
`default_nettype none

module keyed_receipt_mailbox_top
    import krm_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [1:0]        action,
    input  wire logic [DEST_W-1:0] dest_id,
    input  wire logic [KIND_W-1:0] receipt_kind,
    input  wire logic [AUX_W-1:0]  aux_id,
    input  wire logic [WORD_W-1:0] handler,
    input  wire logic [WORD_W-1:0] param,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STAT_W-1:0]      status,
    output logic [KIND_W-1:0]      out_kind,
    output logic [AUX_W-1:0]       out_aux_id,
    output logic [WORD_W-1:0]      out_handler,
    output logic [WORD_W-1:0]      out_arg,
    output logic [RCNT_W-1:0]      removed_count
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    action_t             op_reg;
    slot_t               push_reg;
    logic [CNT_W-1:0]    count_reg;

    logic                out_valid_reg;
    logic [STAT_W-1:0]   status_reg;
    slot_t               out_slot_reg;
    logic [RCNT_W-1:0]   rcnt_reg;

    cell_ctrl_t          ctrl;
    link_t               link   [DEPTH+1];
    logic                hit    [DEPTH+1];
    logic                pv     [DEPTH+1];
    slot_t               sel    [DEPTH];
    slot_t               pop_slot;

    logic                accept;
    logic                exec_go;
    logic                any_match;
    logic                full;
    logic                finish;
    logic [STAT_W-1:0]   status_next;
    logic [RCNT_W-1:0]   rcnt_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign exec_go   = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    assign any_match = hit[DEPTH];
    assign full      = pv[DEPTH];

    assign ctrl.compare = accept;
    assign ctrl.push    = exec_go && (op_reg == ACT_PUSH);
    assign ctrl.remove  = exec_go && ((op_reg == ACT_POP) || (op_reg == ACT_PURGE));

    assign link[DEPTH] = '0;
    assign hit[0]      = 1'b0;
    assign pv[0]       = 1'b1;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        krm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .key        (dest_id),
            .push_slot  (push_reg),
            .prev_valid (pv[i]),
            .hit_in     (hit[i]),
            .up         (link[i+1]),
            .down       (link[i]),
            .hit_out    (hit[i+1]),
            .sel_slot   (sel[i])
        );
        assign pv[i+1] = link[i].valid;
    end

    // only the first matching cell drives a nonzero word
    always_comb
    begin
        pop_slot = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            pop_slot = pop_slot | sel[i];
        end
    end

    assign finish = exec_go && ((op_reg != ACT_PURGE) || !any_match);

    always_comb
    begin
        status_next = STAT_OK;
        rcnt_next   = '0;
        case (op_reg) inside
            ACT_PUSH:  status_next = full ? STAT_FULL : STAT_OK;
            ACT_POP, ACT_QUERY:
                       status_next = any_match ? STAT_OK : STAT_NOMATCH;
            default:
            begin
                status_next = STAT_OK;
                rcnt_next   = (count_reg > CNT_W'(31)) ? RCNT_W'(31)
                                                        : count_reg[RCNT_W-1:0];
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  if (finish) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                count_reg <= '0;
            end
            else if (exec_go && (op_reg == ACT_PURGE) && any_match)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg           <= action_t'(action);
            push_reg.dest    <= dest_id;
            push_reg.kind    <= receipt_kind;
            push_reg.aux     <= aux_id;
            push_reg.handler <= handler;
            push_reg.param   <= param;
        end
        if (finish)
        begin
            status_reg   <= status_next;
            rcnt_reg     <= rcnt_next;
            out_slot_reg <= ((op_reg == ACT_POP) && any_match) ? pop_slot : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign out_kind      = out_slot_reg.kind;
    assign out_aux_id    = out_slot_reg.aux;
    assign out_handler   = out_slot_reg.handler;
    assign out_arg       = out_slot_reg.param;
    assign removed_count = rcnt_reg;

endmodule

`default_nettype wire

// File: rtl/core/krm_checker.sv
// ----------------------------------------------------------------------------
// krm_checker
// Port-level checks for the keyed receipt mailbox, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module krm_checker
    import krm_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              in_valid,
    input wire logic              in_ready,
    input wire logic              out_valid,
    input wire logic              out_ready,
    input wire logic [STAT_W-1:0] status,
    input wire logic [KIND_W-1:0] out_kind,
    input wire logic [WORD_W-1:0] out_handler,
    input wire logic [RCNT_W-1:0] removed_count
);

    // one command in flight: busy right after a beat is taken
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after accept");

    // the result comes only from the execute step, never straight from accept
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !out_valid |=> !out_valid)
        else $error("result beat one cycle after accept");

    a_nomatch_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == STAT_NOMATCH) |->
            (out_kind == '0) && (out_handler == '0) && (removed_count == '0))
        else $error("no-match result carries payload");

    a_count_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (removed_count != '0) |-> (status == STAT_OK))
        else $error("purge count with bad status");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status)
            && $stable(removed_count))
        else $error("stalled result beat changed");

endmodule

bind keyed_receipt_mailbox_top krm_checker u_krm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .out_kind      (out_kind),
    .out_handler   (out_handler),
    .removed_count (removed_count)
);

`default_nettype wire
